### design/u16x8_pkg.sv
// Shared types, constants and UTF-16 / UTF-8 helper functions for the
// UTF-16LE string extractor. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u16x8_pkg;

	localparam int MIN_W = 5;
	localparam logic [MIN_W-1:0] MIN_LEN_RST = 5'd4;

	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_TAB   = 16'h0009;
	localparam logic [15:0] CH_LF    = 16'h000A;
	localparam logic [15:0] CH_CR    = 16'h000D;
	localparam logic [15:0] HI_SURR_LO = 16'hD800;
	localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
	localparam logic [15:0] LO_SURR_LO = 16'hDC00;
	localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;

	// Controller -> datapath commands
	typedef struct packed {
		logic take_unit;
		logic clear_run;
		logic emit_byte;
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic unit_zero;
		logic unit_ctrl;
		logic eod;
		logic run_emit;
		logic str_end;
		logic out_free;
	} sts_t;

	// Control unit: below space, not tab, LF or CR
	function automatic logic is_ctrl(input logic [15:0] u);
		return (u < CH_SPACE) && (u != CH_TAB) && (u != CH_LF) && (u != CH_CR);
	endfunction

	// Index of the final UTF-8 byte of a code point (byte count minus one)
	function automatic logic [1:0] utf8_last(input logic [20:0] cp);
		logic [1:0] r;
		if (cp[20:16] != 5'd0) r = 2'd3;
		else if (cp[15:11] != 5'd0) r = 2'd2;
		else if (cp[10:7] != 4'd0) r = 2'd1;
		else r = 2'd0;
		return r;
	endfunction

	// Byte at position pos of the UTF-8 encoding of cp
	function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp,
			input logic [1:0] last, input logic [1:0] pos);
		logic [7:0] b;
		logic [1:0] from_end;
		from_end = last - pos;
		if (pos == 2'd0) begin
			case (last)
				2'd0: b = {1'b0, cp[6:0]};
				2'd1: b = {3'b110, cp[10:6]};
				2'd2: b = {4'b1110, cp[15:12]};
				default: b = {5'b11110, cp[20:18]};
			endcase
		end else begin
			case (from_end)
				2'd0: b = {2'b10, cp[5:0]};
				2'd1: b = {2'b10, cp[11:6]};
				default: b = {2'b10, cp[17:12]};
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

### design/utf16le_string_extractor_utf8.sv
// Top level of the UTF-16LE string extractor with UTF-8 output.
// Instantiates u16x8_ctrl and u16x8_dp; depends on u16x8_pkg.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   utf16_unit[15:0], end_of_data
//   out      out  out_valid/out_stall utf8_byte[7:0], last_byte, truncated
//   cfg      in   cfg_wr_en           cfg_wr_data[4:0] (min_length)
//
// A unit that does not end a run never stalls the input. A unit that ends an
// emitted run is followed by its UTF-8 bytes (1 to 4 per code point, up to
// 3 * MAX_UNITS per string), one byte per cycle from the single-byte encoder
// and output register; in_stall is high for that replay; out_stall pauses it.
// Reset clears the run, the output register and sets min_length to 4.
`timescale 1ns / 1ps
`default_nettype none

module utf16le_string_extractor_utf8 import u16x8_pkg::*; #(
	parameter int MAX_UNITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [15:0]      utf16_unit,
	input  wire logic             end_of_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [7:0]            utf8_byte,
	output logic                  last_byte,
	output logic                  truncated,
	input  wire logic             cfg_wr_en,
	input  wire logic [MIN_W-1:0] cfg_wr_data
);

	cmd_t cmd;
	sts_t sts;

	u16x8_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	u16x8_dp #(
		.MAX_UNITS (MAX_UNITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.utf16_unit  (utf16_unit),
		.end_of_data (end_of_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.utf8_byte   (utf8_byte),
		.last_byte   (last_byte),
		.truncated   (truncated)
	);

endmodule

`default_nettype wire

### design/u16x8_dp.sv
// Datapath: unit store, run counters, min_length register, UTF-8 encoder
// and output register. Depends on u16x8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u16x8_dp import u16x8_pkg::*; #(
	parameter int MAX_UNITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [15:0]      utf16_unit,
	input  wire logic             end_of_data,
	input  wire logic             cfg_wr_en,
	input  wire logic [MIN_W-1:0] cfg_wr_data,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output logic [7:0]            utf8_byte,
	output logic                  last_byte,
	output logic                  truncated
);

	localparam int CW = $clog2(MAX_UNITS + 2);
	localparam int IW = $clog2(MAX_UNITS);
	localparam int LW = (CW > MIN_W) ? CW : MIN_W;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_UNITS);
	localparam logic [LW-1:0] OVF_LEN = LW'(MAX_UNITS + 1);

	logic [15:0]      store_q [MAX_UNITS];
	logic [CW-1:0]    count_q;
	logic             ovf_q;
	logic [1:0]       pos_q;
	logic [MIN_W-1:0] min_len_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             trunc_q;

	logic [15:0]   cur, nxt;
	logic          full, pair, cp_end;
	logic [20:0]   cp;
	logic [1:0]    last_pos;
	logic [CW-1:0] step, cnt_nx;
	logic          ovf_nx;
	logic [LW-1:0] run_len;
	logic [7:0]    byte_nx;

	// Head of store and code point being replayed
	always_comb begin
		cur = store_q[0];
		nxt = store_q[1];
		full = (count_q == CNT_MAX);
		pair = (cur >= HI_SURR_LO) && (cur <= HI_SURR_HI) && (count_q >= CW'(2))
			&& (nxt >= LO_SURR_LO) && (nxt <= LO_SURR_HI);
		cp = pair ? (SUPP_BASE + {1'b0, cur[9:0], nxt[9:0]}) : {5'd0, cur};
		last_pos = utf8_last(cp);
		byte_nx = utf8_byte_at(cp, last_pos, pos_q);
		cp_end = (pos_q == last_pos);
		step = pair ? CW'(2) : CW'(1);
	end

	// Run length as it would stand after the present input unit
	always_comb begin
		cnt_nx = (utf16_unit == 16'd0 || full) ? count_q : count_q + CW'(1);
		ovf_nx = ovf_q | ((utf16_unit != 16'd0) & full);
		run_len = ovf_nx ? OVF_LEN : LW'(cnt_nx);
	end

	always_comb begin
		sts.unit_zero = (utf16_unit == 16'd0);
		sts.unit_ctrl = is_ctrl(utf16_unit);
		sts.eod       = end_of_data;
		sts.run_emit  = (cnt_nx != '0) && (run_len >= LW'(min_len_q));
		sts.str_end   = cp_end && (count_q == step);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// Control registers: counters, config, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			pos_q       <= 2'd0;
			min_len_q   <= MIN_LEN_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) min_len_q <= cfg_wr_data;
			if (cmd.clear_run) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				pos_q   <= 2'd0;
			end else if (cmd.take_unit) begin
				if (full) ovf_q <= 1'b1;
				else count_q <= count_q + CW'(1);
			end else if (cmd.emit_byte) begin
				if (cp_end) begin
					pos_q   <= 2'd0;
					count_q <= count_q - step;
				end else begin
					pos_q <= pos_q + 2'd1;
				end
			end
			if (cmd.emit_byte) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Unit store: append on collect, shift down as code points are replayed
	always_ff @(posedge clk) begin
		if (cmd.take_unit && !full) begin
			store_q[count_q[IW-1:0]] <= utf16_unit;
		end else if (cmd.emit_byte && cp_end) begin
			for (int i = 0; i < MAX_UNITS; i++) begin
				if (pair) begin
					if (i + 2 < MAX_UNITS) store_q[i] <= store_q[i + 2];
				end else begin
					if (i + 1 < MAX_UNITS) store_q[i] <= store_q[i + 1];
				end
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_byte) begin
			byte_q  <= byte_nx;
			last_q  <= sts.str_end;
			trunc_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign utf8_byte = byte_q;
	assign last_byte = last_q;
	assign truncated = trunc_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX) else $error("unit count above store depth");
	a_ovf_held: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q != '0)) else $error("overflow with empty store");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (pos_q <= last_pos)) else $error("byte position past code point");

endmodule

`default_nettype wire

### design/u16x8_ctrl.sv
// Controller: collect / replay state machine, input stall and datapath
// commands. Depends on u16x8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u16x8_ctrl import u16x8_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_EMIT = 1'b1;

	logic [0:0] state_q, state_d;

	// Next state and commands
	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_stall = (state_q == ST_EMIT);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.unit_zero) begin
						if (sts.run_emit) state_d = ST_EMIT;
						else cmd.clear_run = 1'b1;
					end else if (sts.unit_ctrl) begin
						cmd.clear_run = 1'b1;
					end else begin
						cmd.take_unit = 1'b1;
						if (sts.eod) begin
							if (sts.run_emit) state_d = ST_EMIT;
							else cmd.clear_run = 1'b1;
						end
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_byte = 1'b1;
					if (sts.str_end) begin
						cmd.clear_run = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.take_unit && cmd.emit_byte)) else $error("collect and replay together");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !in_valid) |=> (state_q == ST_IDLE))
		else $error("replay started without a transfer");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !(sts.out_free && sts.str_end)) |=> (state_q == ST_EMIT))
		else $error("replay left before final byte");

endmodule

`default_nettype wire

### bench/tb_utf16le_string_extractor_utf8.sv
// Self-checking bench for utf16le_string_extractor_utf8: directed and random UTF-16 runs,
// checked against a cycle-free model of the run buffer and UTF-8 encoder.
// Depends on u16x8_pkg and the extractor RTL; no files or arguments are read.
`timescale 1ns / 1ps

module tb_utf16le_string_extractor_utf8;
	import u16x8_pkg::*;

	localparam int MAX_UNITS = 16;
	localparam logic [15:0] NUL_UNIT = 16'h0000;
	localparam int TAIL_CYCLES = 8;

	// One expected output transfer
	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       trunc;
	} utf8_out_t;

	// Scoreboard: tracks the run being collected and the UTF-8 bytes it will produce
	class utf8_scoreboard;
		logic [15:0]      run_units [MAX_UNITS];
		int unsigned      run_len;
		bit               run_overflow;
		logic [MIN_W-1:0] min_len;
		utf8_out_t        byte_q [$];
		int unsigned      errors;
		int unsigned      bytes_checked;
		int unsigned      strings_done;
		int unsigned      trunc_done;

		function new();
			run_len = 0;
			run_overflow = 1'b0;
			min_len = MIN_LEN_RST;
			errors = 0;
			bytes_checked = 0;
			strings_done = 0;
			trunc_done = 0;
		endfunction

		function void set_min_len(input logic [MIN_W-1:0] v);
			min_len = v;
		endfunction

		function int pending();
			return byte_q.size();
		endfunction

		function void add_byte(input logic [7:0] b);
			utf8_out_t o;
			o.value = b;
			o.last = 1'b0;
			o.trunc = run_overflow;
			byte_q.insert(byte_q.size(), o);
		endfunction

		function void add_code_point(input logic [20:0] cp);
			if (cp <= 21'h7F) begin
				add_byte({1'b0, cp[6:0]});
			end else if (cp <= 21'h7FF) begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end else if (cp <= 21'hFFFF) begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end else begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endfunction

		// Close the run: replay it as UTF-8 if long enough, then empty the buffer
		function void end_run();
			int unsigned i;
			int unsigned eff_len;
			int unsigned start_size;
			logic [15:0] hi;
			logic [15:0] lo;
			utf8_out_t   tail;
			// an overflowed run counts as one unit past the buffer
			eff_len = run_overflow ? MAX_UNITS + 1 : run_len;
			start_size = byte_q.size();
			if (run_len != 0 && eff_len >= min_len) begin
				i = 0;
				while (i < run_len) begin
					hi = run_units[i];
					lo = (i + 1 < run_len) ? run_units[i + 1] : NUL_UNIT;
					if (hi >= HI_SURR_LO && hi <= HI_SURR_HI && i + 1 < run_len &&
							lo >= LO_SURR_LO && lo <= LO_SURR_HI) begin
						add_code_point(SUPP_BASE + {1'b0, hi[9:0], lo[9:0]});
						i += 2;
					end else begin
						// lone surrogates are encoded as plain 16-bit values
						add_code_point({5'd0, hi});
						i++;
					end
				end
				if (byte_q.size() > start_size) begin
					tail = byte_q[$];
					tail.last = 1'b1;
					byte_q[$] = tail;
				end
			end
			run_len = 0;
			run_overflow = 1'b0;
		endfunction

		// Accepted input transfer
		function void note_unit(input logic [15:0] u, input logic eod);
			if (u == NUL_UNIT) begin
				end_run();
				return;
			end
			// control unit throws the run away, even at end of data
			if (u < CH_SPACE && u != CH_TAB && u != CH_LF && u != CH_CR) begin
				run_len = 0;
				run_overflow = 1'b0;
				return;
			end
			if (run_len < MAX_UNITS) begin
				run_units[run_len] = u;
				run_len++;
			end else begin
				run_overflow = 1'b1;
			end
			if (eod)
				end_run();
		endfunction

		// Accepted output transfer
		function void check_byte(input logic [7:0] b, input logic l, input logic t);
			utf8_out_t want;
			if (byte_q.size() == 0) begin
				$error("unexpected output: utf8_byte %h last_byte %b truncated %b", b, l, t);
				errors++;
				return;
			end
			want = byte_q.pop_front();
			if (b !== want.value) begin
				$error("utf8_byte mismatch: expected %h, got %h", want.value, b);
				errors++;
			end
			if (l !== want.last) begin
				$error("last_byte mismatch: expected %b, got %b", want.last, l);
				errors++;
			end
			if (t !== want.trunc) begin
				$error("truncated mismatch: expected %b, got %b", want.trunc, t);
				errors++;
			end
			bytes_checked++;
			if (want.last) begin
				strings_done++;
				if (want.trunc)
					trunc_done++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [15:0]      utf16_unit = 16'h0000;
	logic             end_of_data = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       utf8_byte;
	logic             last_byte;
	logic             truncated;
	logic             cfg_wr_en = 1'b0;
	logic [MIN_W-1:0] cfg_wr_data = '0;

	utf8_scoreboard sb;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_left = 0;
	int hold_total = 0;
	int items_sent = 0;
	int cfg_writes = 0;
	logic [MIN_W-1:0] cur_min_len = MIN_LEN_RST;

	utf16le_string_extractor_utf8 #(.MAX_UNITS(MAX_UNITS)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.utf16_unit  (utf16_unit),
		.end_of_data (end_of_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.utf8_byte   (utf8_byte),
		.last_byte   (last_byte),
		.truncated   (truncated),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Output side: check each transfer, then pick next cycle's stall
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_byte(utf8_byte, last_byte, truncated);
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Offer one unit, with a random gap first, and wait for the transfer
	task automatic send_unit(input logic [15:0] u, input logic eod);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		utf16_unit <= u;
		end_of_data <= eod;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_unit(u, eod);
		items_sent++;
	endtask

	// Stop offering and let every expected byte come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_min_length(input logic [MIN_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_min_len(v);
		cur_min_len = v;
		cfg_writes++;
	endtask

	function automatic logic [15:0] rand_text_unit();
		logic [15:0] u;
		case ($urandom_range(8))
			0, 1, 2: u = 16'($urandom_range(16'h7E, 16'h20));
			3: begin
				case ($urandom_range(2))
					0: u = CH_TAB;
					1: u = CH_LF;
					default: u = CH_CR;
				endcase
			end
			4: u = 16'($urandom_range(16'h7FF, 16'h80));
			5: u = 16'($urandom_range(16'hD7FF, 16'h800));
			6: u = 16'($urandom_range(16'hFFFF, 16'hE000));
			7: u = 16'($urandom_range(LO_SURR_HI, LO_SURR_LO));
			default: u = 16'($urandom_range(HI_SURR_HI, HI_SURR_LO));
		endcase
		return u;
	endfunction

	function automatic logic [15:0] rand_ctrl_unit();
		logic [15:0] u;
		do
			u = 16'($urandom_range(CH_SPACE - 1, 1));
		while (u == CH_TAB || u == CH_LF || u == CH_CR);
		return u;
	endfunction

	// Run length clustered around the current threshold, sometimes anywhere
	function automatic int pick_run_length();
		int lo;
		int hi;
		if ($urandom_range(4) == 0)
			return $urandom_range(MAX_UNITS + 4, 1);
		lo = (cur_min_len >= 3) ? cur_min_len - 2 : 1;
		hi = (cur_min_len + 2 > MAX_UNITS + 4) ? MAX_UNITS + 4 : cur_min_len + 2;
		if (lo > hi)
			lo = hi;
		return $urandom_range(hi, lo);
	endfunction

	// Mostly well-formed runs; some noise and some runs broken by a control unit
	task automatic send_run();
		int kind;
		int len;
		int i;
		bit by_eod;
		kind = $urandom_range(99);
		if (kind < 15) begin
			len = $urandom_range(8, 1);
			for (i = 0; i < len; i++)
				send_unit(16'(($urandom_range(3) == 0) ? $urandom_range(31)
					: $urandom_range(16'hFFFF)), $urandom_range(9) == 0);
		end else begin
			len = pick_run_length();
			by_eod = (kind >= 27) && ($urandom_range(1) != 0);
			i = 0;
			while (i < len) begin
				if (i + 1 < len && $urandom_range(4) == 0) begin
					send_unit(16'($urandom_range(HI_SURR_HI, HI_SURR_LO)), 1'b0);
					send_unit(16'($urandom_range(LO_SURR_HI, LO_SURR_LO)),
						by_eod && i + 2 == len);
					i += 2;
				end else begin
					send_unit(rand_text_unit(), by_eod && i + 1 == len);
					i++;
				end
			end
			if (kind < 27)
				send_unit(rand_ctrl_unit(), 1'($urandom_range(1)));
			else if (!by_eod)
				send_unit(NUL_UNIT, 1'($urandom_range(1)));
		end
	endtask

	task automatic send_random(input int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal)
			send_run();
	endtask

	// Directed runs at the reset threshold of four units
	task automatic run_directed();
		// overflowing run: code point extremes, pairs, lone low surrogate,
		// whitespace, and a high surrogate whose partner is dropped
		send_unit(16'h0020, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(CH_TAB, 1'b0);
		send_unit(CH_LF, 1'b0);
		send_unit(CH_CR, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(NUL_UNIT, 1'b0);
		// empty run ended by a zero unit that also marks end of data
		send_unit(NUL_UNIT, 1'b1);
		// short run
		send_unit(16'h0041, 1'b0);
		send_unit(NUL_UNIT, 1'b0);
		// control unit mid-run, then control unit at end of data
		send_unit(16'h0042, 1'b0);
		send_unit(16'h0001, 1'b0);
		send_unit(16'h0043, 1'b0);
		send_unit(16'h001F, 1'b1);
		// run ended by end of data; lone high surrogates, one of them last
		send_unit(16'h0044, 1'b0);
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0046, 1'b0);
		send_unit(16'hDBFF, 1'b1);
	endtask

	// Stimulus sequence
	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 16;
		rx_idle_pct = 47;
		run_directed();
		wait_idle();
		write_min_length(5'd1);
		send_random(50);

		wait_idle();
		tx_idle_pct = 47;
		rx_idle_pct = 16;
		write_min_length(5'd17);
		send_random(50);

		wait_idle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_min_length(5'd0);
		send_random(25);
		// long output hold-off while units keep coming
		hold_left = 300;
		hold_total += 300;
		send_random(30);

		wait_idle();
		write_min_length(5'd31);
		send_random(15);

		wait_idle();
		write_min_length(5'd16);
		send_random(30);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d code units under %0d min_length settings, %0d cycles of output hold-off.",
			items_sent, cfg_writes + 1, hold_total);
		$display("Checked %0d UTF-8 bytes forming %0d strings, %0d of them truncated.",
			sb.bytes_checked, sb.strings_done, sb.trunc_done);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
